>>> src/nmt_pkg.sv
// nmt_pkg: types, codes and helpers shared by the NAT mapping table.
// No dependencies.
`default_nettype none
package nmt_pkg;

	localparam int TableEntriesDef = 64;
	localparam int CfgIdxW         = 8;

	typedef enum logic [1:0] {
		OP_INSERT     = 2'd0,
		OP_LOOKUP_INT = 2'd1,
		OP_LOOKUP_EXT = 2'd2,
		OP_TICK       = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK   = 2'd0,
		STATUS_MISS = 2'd1,
		STATUS_FULL = 2'd2
	} status_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_MIN_PORT = 8'd0,
		REG_MAX_PORT = 8'd1,
		REG_ICMP_TO  = 8'd2,
		REG_TCP_TO   = 8'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROBE,
		ST_SEL,
		ST_EXPIRE,
		ST_COMPACT
	} state_t;

	localparam logic [15:0] MinPortRst = 16'd1024;
	localparam logic [15:0] MaxPortRst = 16'd65535;
	localparam logic [31:0] IcmpToRst  = 32'd60;
	localparam logic [31:0] TcpToRst   = 32'd7440;

	typedef struct packed {
		logic        valid;
		logic        proto;
		logic [31:0] int_addr;
		logic [15:0] int_port;
		logic [15:0] ext_port;
		logic [31:0] last_seen;
	} entry_t;

	typedef struct packed {
		logic        proto;
		logic        by_ext;
		logic [31:0] int_addr;
		logic [15:0] int_port;
		logic [15:0] ext_port;
	} key_t;

	typedef struct packed {
		logic        shift;
		logic        compact;
		logic        expire;
		logic        cmp_en;
		key_t        key;
		logic [31:0] now;
		logic [31:0] icmp_to;
		logic [31:0] tcp_to;
	} cell_ctl_t;

	function automatic logic [15:0] step_port(input logic [15:0] p,
			input logic [15:0] minp, input logic [15:0] maxp);
		logic [15:0] r;
		if (p == maxp) r = minp;
		else           r = p + 16'd1;
		return r;
	endfunction

endpackage
`default_nettype wire

>>> src/nmt_cell.sv
// nmt_cell: one slot of the mapping table chain; holds an entry, matches the
// broadcast key and moves entries to and from its neighbours. Uses nmt_pkg.
`default_nettype none
module nmt_cell import nmt_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cell_ctl_t ctl,
	input  wire logic      refresh,
	input  wire entry_t    prev_ent,
	input  wire entry_t    next_ent,
	output entry_t         ent,
	output logic           hit
);
	logic        valid_q;
	logic        proto_q;
	logic [31:0] addr_q;
	logic [15:0] iport_q;
	logic [15:0] eport_q;
	logic [31:0] seen_q;
	logic        hit_q;
	logic [31:0] idle;
	logic [31:0] limit;
	logic        expired;
	logic        pull;
	logic        match;

	assign idle    = ctl.now - seen_q;
	assign limit   = proto_q ? ctl.tcp_to : ctl.icmp_to;
	assign expired = idle > limit;
	// hole here and a live entry below: pull it up
	assign pull    = ctl.compact && !valid_q && next_ent.valid;

	assign match = valid_q && (proto_q == ctl.key.proto) &&
		(ctl.key.by_ext ? (eport_q == ctl.key.ext_port)
		                : (addr_q == ctl.key.int_addr && iport_q == ctl.key.int_port));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (ctl.shift) begin
				valid_q <= prev_ent.valid;
			end else if (pull) begin
				valid_q <= 1'b1;
			end else if (ctl.compact && valid_q && !prev_ent.valid) begin
				valid_q <= 1'b0;
			end else if (ctl.expire && valid_q && expired) begin
				valid_q <= 1'b0;
			end
			if (ctl.cmp_en) begin
				hit_q <= match;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			proto_q <= prev_ent.proto;
			addr_q  <= prev_ent.int_addr;
			iport_q <= prev_ent.int_port;
			eport_q <= prev_ent.ext_port;
			seen_q  <= prev_ent.last_seen;
		end else if (pull) begin
			proto_q <= next_ent.proto;
			addr_q  <= next_ent.int_addr;
			iport_q <= next_ent.int_port;
			eport_q <= next_ent.ext_port;
			seen_q  <= next_ent.last_seen;
		end else if (refresh) begin
			seen_q <= ctl.now;
		end
	end

	assign ent = '{valid: valid_q, proto: proto_q, int_addr: addr_q,
		int_port: iport_q, ext_port: eport_q, last_seen: seen_q};
	assign hit = hit_q;

endmodule
`default_nettype wire

>>> src/nat_mapping_table.sv
// nat_mapping_table: NAPT mapping table built as a chain of entry cells.
// Lookups compare at accept and select in ST_SEL once output is free; a result word
// may sit in the output register while the next word is accepted.
// Inserts probe candidate ports one per cycle, skipping each port found in use.
// A tick advances time, expires stale entries, then compacts until no hole lies above a live entry.
// Reset (arst_n low) empties the table, zeroes time, loads register defaults.
`default_nettype none
module nat_mapping_table import nmt_pkg::*; #(
	parameter int TABLE_ENTRIES = TableEntriesDef
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         op,
	input  wire logic               proto,
	input  wire logic [31:0]        int_addr,
	input  wire logic [15:0]        int_port,
	input  wire logic [15:0]        ext_port,
	// result channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              status,
	output logic                    out_proto,
	output logic [31:0]             out_int_addr,
	output logic [15:0]             out_int_port,
	output logic [15:0]             out_ext_port,
	// register writes
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [31:0]        cfg_data
);
	localparam int TriesW = $clog2(TABLE_ENTRIES);
	localparam logic [TriesW-1:0] LastTry = TriesW'(TABLE_ENTRIES - 1);

	state_t state_q, state_d;

	// configuration
	logic [15:0] min_port_q, max_port_q;
	logic [31:0] icmp_to_q, tcp_to_q;

	// held item and insert search
	logic              proto_q;
	logic [31:0]       addr_q;
	logic [15:0]       iport_q;
	logic [15:0]       cand_q;
	logic [TriesW-1:0] tries_q;
	logic [15:0]       next_tcp_q, next_icmp_q;
	logic [31:0]       now_q;

	// output register
	logic        out_valid_q;
	logic [1:0]  status_q;
	logic        oproto_q;
	logic [31:0] oaddr_q;
	logic [15:0] oiport_q, oeport_q;

	// chain
	entry_t                   ent [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] hit;
	logic [TABLE_ENTRIES-1:0] sel;
	logic [TABLE_ENTRIES-1:0] refresh;
	cell_ctl_t                ctl;
	entry_t                   new_ent;
	entry_t                   tail_ent;

	logic accept, out_free, any_hit, pairs;
	logic emit, load_item, step_cand, take_port, tick_now;
	logic [1:0] emit_status;
	entry_t     emit_ent;
	entry_t     found_ent;
	logic [15:0] cand_next;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign any_hit  = |hit;
	// newest match only: isolate the lowest set bit
	assign sel      = hit & (~hit + TABLE_ENTRIES'(1));
	assign cand_next = step_port(cand_q, min_port_q, max_port_q);

	assign new_ent  = '{valid: 1'b1, proto: proto_q, int_addr: addr_q,
		int_port: iport_q, ext_port: cand_q, last_seen: now_q};
	assign tail_ent = '0;

	always_comb begin
		found_ent = '0;
		pairs     = 1'b0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (sel[i]) found_ent = found_ent | ent[i];
		end
		for (int i = 0; i < TABLE_ENTRIES - 1; i++) begin
			pairs = pairs | (!ent[i].valid && ent[i+1].valid);
		end
	end

	// cell row
	for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
		entry_t p_ent, n_ent;
		if (g == 0) begin : g_head
			assign p_ent = new_ent;
		end else begin : g_body
			assign p_ent = ent[g-1];
		end
		if (g == TABLE_ENTRIES - 1) begin : g_tail
			assign n_ent = tail_ent;
		end else begin : g_mid
			assign n_ent = ent[g+1];
		end
		nmt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.refresh  (refresh[g]),
			.prev_ent (p_ent),
			.next_ent (n_ent),
			.ent      (ent[g]),
			.hit      (hit[g])
		);
	end

	// sequencer
	always_comb begin
		state_d     = state_q;
		emit        = 1'b0;
		emit_status = STATUS_OK;
		emit_ent    = '0;
		load_item   = 1'b0;
		step_cand   = 1'b0;
		take_port   = 1'b0;
		tick_now    = 1'b0;
		refresh     = '0;
		ctl         = '0;
		ctl.now     = now_q;
		ctl.icmp_to = icmp_to_q;
		ctl.tcp_to  = tcp_to_q;
		unique case (state_q)
			ST_IDLE: begin
				// compare straight off the input word
				ctl.key.proto    = proto;
				ctl.key.by_ext   = (op != OP_LOOKUP_INT);
				ctl.key.int_addr = int_addr;
				ctl.key.int_port = int_port;
				ctl.key.ext_port = (op == OP_INSERT) ?
					(proto ? next_tcp_q : next_icmp_q) : ext_port;
				if (accept) begin
					load_item = 1'b1;
					if (op == OP_TICK) begin
						tick_now = 1'b1;
						state_d  = ST_EXPIRE;
					end else begin
						ctl.cmp_en = 1'b1;
						state_d    = (op == OP_INSERT) ? ST_PROBE : ST_SEL;
					end
				end
			end
			ST_PROBE: begin
				ctl.key.proto    = proto_q;
				ctl.key.by_ext   = 1'b1;
				ctl.key.ext_port = cand_next;
				if (ent[TABLE_ENTRIES-1].valid || (any_hit && tries_q == LastTry)) begin
					if (out_free) begin
						emit        = 1'b1;
						emit_status = STATUS_FULL;
						state_d     = ST_IDLE;
					end
				end else if (any_hit) begin
					step_cand  = 1'b1;
					ctl.cmp_en = 1'b1;
				end else if (out_free) begin
					ctl.shift   = 1'b1;
					take_port   = 1'b1;
					emit        = 1'b1;
					emit_status = STATUS_OK;
					emit_ent    = new_ent;
					state_d     = ST_IDLE;
				end
			end
			ST_SEL: begin
				if (out_free) begin
					emit     = 1'b1;
					refresh  = sel;
					state_d  = ST_IDLE;
					if (any_hit) begin
						emit_status = STATUS_OK;
						emit_ent    = found_ent;
					end else begin
						emit_status = STATUS_MISS;
					end
				end
			end
			ST_EXPIRE: begin
				ctl.expire = 1'b1;
				state_d    = ST_COMPACT;
			end
			ST_COMPACT: begin
				if (pairs) ctl.compact = 1'b1;
				else       state_d     = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// configuration, counters, time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_port_q  <= MinPortRst;
			max_port_q  <= MaxPortRst;
			icmp_to_q   <= IcmpToRst;
			tcp_to_q    <= TcpToRst;
			next_tcp_q  <= MinPortRst;
			next_icmp_q <= MinPortRst;
			now_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_MIN_PORT: min_port_q <= cfg_data[15:0];
					REG_MAX_PORT: max_port_q <= cfg_data[15:0];
					REG_ICMP_TO:  icmp_to_q  <= cfg_data;
					REG_TCP_TO:   tcp_to_q   <= cfg_data;
					default: ;
				endcase
			end
			if (take_port) begin
				if (proto_q) next_tcp_q  <= cand_next;
				else         next_icmp_q <= cand_next;
			end
			if (tick_now) now_q <= now_q + 32'd1;
			if (emit)           out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// item hold and result word, no reset needed
	always_ff @(posedge clk) begin
		if (load_item) begin
			proto_q <= proto;
			addr_q  <= int_addr;
			iport_q <= int_port;
			cand_q  <= proto ? next_tcp_q : next_icmp_q;
			tries_q <= '0;
		end else if (step_cand) begin
			cand_q  <= cand_next;
			tries_q <= tries_q + TriesW'(1);
		end
		if (emit) begin
			status_q <= emit_status;
			oproto_q <= emit_ent.proto;
			oaddr_q  <= emit_ent.int_addr;
			oiport_q <= emit_ent.int_port;
			oeport_q <= emit_ent.ext_port;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_proto    = oproto_q;
	assign out_int_addr = oaddr_q;
	assign out_int_port = oiport_q;
	assign out_ext_port = oeport_q;

endmodule
`default_nettype wire

>>> src/nmt_checker.sv
// nmt_checker: port-level assertions for nat_mapping_table, bound below.
// Uses nmt_pkg.
`default_nettype none
module nmt_checker import nmt_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [1:0]  status,
	input wire logic        out_proto,
	input wire logic [31:0] out_int_addr,
	input wire logic [15:0] out_int_port,
	input wire logic [15:0] out_ext_port
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STATUS_OK || status == STATUS_MISS ||
			status == STATUS_FULL))
		else $error("bad status code");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STATUS_OK |-> (!out_proto && out_int_addr == 32'd0 &&
			out_int_port == 16'd0 && out_ext_port == 16'd0))
		else $error("miss or full word carries entry fields");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(status) && $stable(out_ext_port))
		else $error("stalled result word changed");

endmodule

bind nat_mapping_table nmt_checker u_nmt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.status       (status),
	.out_proto    (out_proto),
	.out_int_addr (out_int_addr),
	.out_int_port (out_int_port),
	.out_ext_port (out_ext_port)
);
`default_nettype wire
